// ===== rtl/core/ccls_pkg.sv =====
// ----------------------------------------------------------------------------
// ccls_pkg: shared types and constants
// Item struct, type codes, date phases and character codes for the CSV cell
// type classifier.
// ----------------------------------------------------------------------------
package ccls_pkg;

    localparam int YEAR_W  = 14;
    localparam int POS_W   = 4;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 6;

    localparam logic [YEAR_W-1:0] MAX_YEAR_RESET = 14'd2024;

    localparam logic [POS_W-1:0]   POS_SAT   = 4'd11;
    localparam logic [POS_W-1:0]   POS_DATE  = 4'd10; // date never looks past this
    localparam logic [POS_W-1:0]   POS_YSEP  = 4'd4;
    localparam logic [POS_W-1:0]   POS_MSEP  = 4'd7;
    localparam logic [POS_W-1:0]   POS_LAST5 = 4'd4;
    localparam logic [POS_W-1:0]   POS_LAST10 = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;
    localparam logic [MONTH_W-1:0] MONTH_SAT = 4'd13;
    localparam logic [DAY_W-1:0]   DAY_MAX   = 6'd31;
    localparam logic [DAY_W-1:0]   DAY_SAT   = 6'd32;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_4     = 8'h34;
    localparam logic [7:0] CH_8     = 8'h38;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;

    typedef enum logic [2:0] {
        CT_EMPTY   = 3'd0,
        CT_TEXT    = 3'd1,
        CT_DATE    = 3'd2,
        CT_FACULTY = 3'd3,
        CT_NUMBER  = 3'd4
    } t_cell_type;

    typedef enum logic [1:0] {
        DP_YEAR  = 2'd0,
        DP_MONTH = 2'd1,
        DP_DAY   = 2'd2
    } t_date_phase;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
        logic       is_empty;
    } t_item;

    // input register state as seen by the downstream logic
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_in_head;

endpackage

// ===== rtl/core/ccls_in_stage.sv =====
// ----------------------------------------------------------------------------
// ccls_in_stage: input register
// Holds one incoming request; refills in the same cycle it is consumed.
// ----------------------------------------------------------------------------
module ccls_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [7:0]        i_s_tdata,  // [7:0] char_code
    input  logic              i_s_tlast,  // is_last
    input  logic              i_s_tuser,  // [0] is_empty
    input  logic              i_advance,
    output ccls_pkg::t_in_head o_head
);
    import ccls_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  accept;

    assign o_s_tready = !r_valid || i_advance;
    assign accept     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.char_code <= i_s_tdata;
            r_item.is_last   <= i_s_tlast;
            r_item.is_empty  <= i_s_tuser;
        end
    end

    assign o_head.valid = r_valid;
    assign o_head.item  = r_item;

endmodule

// ===== rtl/core/ccls_cell_state.sv =====
// ----------------------------------------------------------------------------
// ccls_cell_state: per-cell scan state and type decision
// Updates date, id and number trackers for one character and gives the
// type code when the character closes the cell.
// ----------------------------------------------------------------------------
module ccls_cell_state (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  ccls_pkg::t_item              i_item,
    input  logic [ccls_pkg::YEAR_W-1:0]  i_max_year,
    output ccls_pkg::t_cell_type         o_cell_type
);
    import ccls_pkg::*;

    logic [POS_W-1:0]   r_position,  n_position;
    logic [7:0]         r_first_char, n_first_char;
    t_date_phase        r_date_phase, n_date_phase;
    logic [YEAR_W-1:0]  r_year,  n_year;
    logic [MONTH_W-1:0] r_month, n_month;
    logic [DAY_W-1:0]   r_day,   n_day;
    logic r_date_ok,  n_date_ok;
    logic r_short_ok, n_short_ok;
    logic r_long_ok,  n_long_ok;
    logic r_num_ok,   n_num_ok;
    logic r_seen_pt,  n_seen_pt;
    logic r_dig_bef,  n_dig_bef;
    logic r_dig_aft,  n_dig_aft;
    logic close_cell;

    logic [7:0] c;
    logic       dig;
    logic       lead;
    logic [3:0] dval;
    logic [7:0] month_acc;
    logic [8:0] day_acc;
    logic       quoted;

    assign c    = i_item.char_code;
    assign dig  = (c >= CH_0) && (c <= CH_9);
    assign lead = (c == CH_0) || (c == CH_1) || (c == CH_3) || (c == CH_4) || (c == CH_8);
    assign dval = c[3:0];  // low nibble of an ASCII digit is its value

    assign month_acc = 8'(r_month) * 8'd10 + 8'(dval);
    assign day_acc   = 9'(r_day) * 9'd10 + 9'(dval);

    always_comb begin
        n_position   = (r_position < POS_SAT) ? r_position + 4'd1 : r_position;
        n_first_char = (r_position == '0) ? c : r_first_char;
        n_date_phase = r_date_phase;
        n_year       = r_year;
        n_month      = r_month;
        n_day        = r_day;
        n_date_ok    = r_date_ok;
        n_short_ok   = r_short_ok;
        n_long_ok    = r_long_ok;
        n_num_ok     = r_num_ok;
        n_seen_pt    = r_seen_pt;
        n_dig_bef    = r_dig_bef;
        n_dig_aft    = r_dig_aft;

        // date
        if (r_date_ok && (r_position < POS_DATE)) begin
            unique case (r_date_phase)
                DP_YEAR: begin
                    if ((r_position < POS_YSEP) && (c != CH_DASH)) begin
                        if (!dig) n_date_ok = 1'b0;
                        else      n_year = YEAR_W'(r_year * 14'd10 + 14'(dval));
                    end else begin
                        if ((r_year == '0) || (r_year > i_max_year) || (c != CH_DASH))
                            n_date_ok = 1'b0;
                        n_date_phase = DP_MONTH;
                    end
                end
                DP_MONTH: begin
                    if ((r_position < POS_MSEP) && (c != CH_DASH)) begin
                        if (!dig) n_date_ok = 1'b0;
                        else      n_month = (month_acc > 8'(MONTH_SAT)) ? MONTH_SAT
                                                                        : month_acc[3:0];
                    end else begin
                        if ((r_month == '0) || (r_month > MONTH_MAX) || (c != CH_DASH))
                            n_date_ok = 1'b0;
                        n_date_phase = DP_DAY;
                    end
                end
                default: begin
                    if (!dig) n_date_ok = 1'b0;
                    else      n_day = (day_acc > 9'(DAY_SAT)) ? DAY_SAT : day_acc[5:0];
                end
            endcase
        end

        // faculty numbers
        if (!dig) n_short_ok = 1'b0;
        if ((r_position == '0) && !lead) n_short_ok = 1'b0;
        if (!dig && (c != CH_M) && (c != CH_I)) n_long_ok = 1'b0;
        if ((r_position == POS_LAST5) && !lead) n_long_ok = 1'b0;

        // signed decimal
        if ((r_position == '0) && (c == CH_DASH)) begin
            n_num_ok = r_num_ok;
        end else if (dig) begin
            if (r_seen_pt) n_dig_aft = 1'b1;
            else           n_dig_bef = 1'b1;
        end else if (c == CH_POINT) begin
            if (r_seen_pt) n_num_ok = 1'b0;
            else           n_seen_pt = 1'b1;
        end else begin
            n_num_ok = 1'b0;
        end
    end

    assign quoted = ((n_first_char == CH_DQUOTE) && (c == CH_DQUOTE)) ||
                    ((n_first_char == CH_SQUOTE) && (c == CH_SQUOTE));

    always_comb begin
        if (i_item.is_empty)
            o_cell_type = CT_EMPTY;
        else if (quoted)
            o_cell_type = CT_TEXT;
        else if ((r_position == POS_LAST10) && n_date_ok && (n_date_phase == DP_DAY) &&
                 (n_day != '0) && (n_day <= DAY_MAX))
            o_cell_type = CT_DATE;
        else if (((r_position == POS_LAST5) && n_short_ok) ||
                 ((r_position == POS_LAST10) && n_long_ok))
            o_cell_type = CT_FACULTY;
        else if (n_num_ok && (n_seen_pt ? (n_dig_bef || n_dig_aft) : n_dig_bef))
            o_cell_type = CT_NUMBER;
        else
            o_cell_type = CT_TEXT;
    end

    assign close_cell = i_item.is_empty || i_item.is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && close_cell)) begin
            r_position   <= '0;
            r_first_char <= '0;
            r_date_phase <= DP_YEAR;
            r_year       <= '0;
            r_month      <= '0;
            r_day        <= '0;
            r_date_ok    <= 1'b1;
            r_short_ok   <= 1'b1;
            r_long_ok    <= 1'b1;
            r_num_ok     <= 1'b1;
            r_seen_pt    <= 1'b0;
            r_dig_bef    <= 1'b0;
            r_dig_aft    <= 1'b0;
        end else if (i_fire) begin
            r_position   <= n_position;
            r_first_char <= n_first_char;
            r_date_phase <= n_date_phase;
            r_year       <= n_year;
            r_month      <= n_month;
            r_day        <= n_day;
            r_date_ok    <= n_date_ok;
            r_short_ok   <= n_short_ok;
            r_long_ok    <= n_long_ok;
            r_num_ok     <= n_num_ok;
            r_seen_pt    <= n_seen_pt;
            r_dig_bef    <= n_dig_bef;
            r_dig_aft    <= n_dig_aft;
        end
    end

endmodule

// ===== rtl/core/csv_cell_type_classifier_top.sv =====
// ----------------------------------------------------------------------------
// csv_cell_type_classifier_top: CSV cell type classifier
// Streams a cell one character per request and returns one type code per
// cell: empty, quoted text, date, faculty number, signed number or plain text.
// ----------------------------------------------------------------------------
// Takes one character request per clock, with no bubbles between cells, unless
// a closing request waits on a full output register. The scan logic updates
// the per-cell trackers from the request in the input register and, on the
// closing character (tlast) or an empty-cell request (tuser), loads the type
// code into the output register: the code is on o_m_tdata in the next cycle.
// Only a closing request waits on a full output register; ordinary
// characters of the next cell keep flowing while a result is held. The
// max_year register is written through i_cfg_wen / i_cfg_wdata and should
// only change between cells.
module csv_cell_type_classifier_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_wen,
    input  logic [13:0] i_cfg_wdata,  // [13:0] max_year
    // character requests
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,    // [7:0] char_code
    input  logic        i_s_tlast,    // is_last
    input  logic        i_s_tuser,    // [0] is_empty
    // type codes
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata     // [2:0] cell_type, [7:3] zero
);
    import ccls_pkg::*;

    logic [YEAR_W-1:0] r_max_year;
    t_in_head          head;
    logic              is_result;
    logic              advance;
    logic              load_out;
    t_cell_type        cell_type;
    logic              r_out_valid;
    t_cell_type        r_out_type;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_year <= MAX_YEAR_RESET;
        end else if (i_cfg_wen) begin
            r_max_year <= i_cfg_wdata;
        end
    end

    ccls_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_s_tuser  (i_s_tuser),
        .i_advance  (advance),
        .o_head     (head)
    );

    // a closing request needs room in the output register
    assign is_result = head.item.is_last || head.item.is_empty;
    assign advance   = head.valid && (!is_result || !r_out_valid || i_m_tready);
    assign load_out  = advance && is_result;

    ccls_cell_state u_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (advance),
        .i_item      (head.item),
        .i_max_year  (r_max_year),
        .o_cell_type (cell_type)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_type <= cell_type;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b0, r_out_type};

`ifndef SYNTH
    // type code stays within the defined set
    a_type_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[2:0] <= 3'(CT_NUMBER)))
        else $error("type code out of range");

    // closing request must not be consumed while a result is stuck
    a_close_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (head.valid && is_result && r_out_valid && !i_m_tready) |-> !advance)
        else $error("closing request consumed over a pending result");

    // each consumed closing request shows up as a result next cycle
    a_result_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> o_m_tvalid)
        else $error("result lost");

    // an ordinary character never produces a result
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!load_out && r_out_valid && i_m_tready) |=> !o_m_tvalid)
        else $error("result invented");
`endif

endmodule
